// File: sv/kesd_pkg.sv
// Shared types and byte constants for the key escape sequence decoder.
`timescale 1ns / 1ps

package kesd_pkg;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_RIGHT       = 4'd1,
        ACT_LEFT        = 4'd2,
        ACT_UP          = 4'd3,
        ACT_DOWN        = 4'd4,
        ACT_SHIFT_LEFT  = 4'd5,
        ACT_ENTER       = 4'd6,
        ACT_SHIFT_RIGHT = 4'd7,
        ACT_TYPED       = 4'd8,
        ACT_QUIT        = 4'd9
    } cmd_t;

    localparam logic [7:0] KEY_BS      = 8'd8;
    localparam logic [7:0] KEY_LF      = 8'd10;
    localparam logic [7:0] KEY_CR      = 8'd13;
    localparam logic [7:0] KEY_ESC     = 8'd27;
    localparam logic [7:0] KEY_SPACE   = 8'd32;
    localparam logic [7:0] KEY_DIGIT_0 = 8'd48;
    localparam logic [7:0] KEY_DIGIT_1 = 8'd49;
    localparam logic [7:0] KEY_DIGIT_2 = 8'd50;
    localparam logic [7:0] KEY_DIGIT_5 = 8'd53;
    localparam logic [7:0] KEY_DIGIT_9 = 8'd57;
    localparam logic [7:0] KEY_UPPER_A = 8'd65;
    localparam logic [7:0] KEY_UPPER_B = 8'd66;
    localparam logic [7:0] KEY_UPPER_C = 8'd67;
    localparam logic [7:0] KEY_UPPER_D = 8'd68;
    localparam logic [7:0] KEY_UPPER_Z = 8'd90;
    localparam logic [7:0] KEY_LBRACKET = 8'd91;
    localparam logic [7:0] KEY_BACKQUOTE = 8'd96;
    localparam logic [7:0] KEY_LOWER_A = 8'd97;
    localparam logic [7:0] KEY_LOWER_Z = 8'd122;
    localparam logic [7:0] KEY_TILDE   = 8'd126;
    localparam logic [7:0] KEY_DEL     = 8'd127;

    // Per-transaction action handed from the parser to the line buffer.
    typedef struct packed {
        cmd_t cmd;
        logic append;
        logic erase;
        logic clear;
    } step_t;

endpackage

// File: sv/kesd_parser.sv
// Escape sequence parser: holds the parser state and classifies each key byte.
`timescale 1ns / 1ps

module kesd_parser
    import kesd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       mode,
    input  logic [7:0] key_byte,
    output step_t      step
);

    typedef enum logic [1:0] {
        PS_IDLE  = 2'd0,
        PS_ESC   = 2'd1,
        PS_CSI   = 2'd2,
        PS_TILDE = 2'd3
    } parse_state_t;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         plain_en;
    logic         is_text;
    cmd_t         seq_cmd;

    always_comb
    begin
        is_text = ((key_byte >= KEY_UPPER_A) && (key_byte <= KEY_UPPER_Z))
               || ((key_byte >= KEY_LOWER_A) && (key_byte <= KEY_LOWER_Z))
               || ((key_byte >= KEY_DIGIT_0) && (key_byte <= KEY_DIGIT_9))
               || (key_byte == KEY_SPACE);
    end

    always_comb
    begin
        state_next = state_reg;
        plain_en   = 1'b0;
        seq_cmd    = ACT_NONE;
        if (mode)
        begin
            state_next = state_reg;
        end
        else if (key_byte == KEY_BACKQUOTE)
        begin
            seq_cmd = ACT_QUIT;
        end
        else
        begin
            case (state_reg)
                PS_IDLE:
                begin
                    if (key_byte == KEY_ESC)
                        state_next = PS_ESC;
                    else
                        plain_en = 1'b1;
                end
                PS_ESC:
                begin
                    if (key_byte == KEY_LBRACKET)
                    begin
                        state_next = PS_CSI;
                    end
                    else
                    begin
                        state_next = PS_IDLE;
                        plain_en   = 1'b1;
                    end
                end
                PS_CSI:
                begin
                    state_next = PS_IDLE;
                    if (key_byte == KEY_UPPER_A)
                        seq_cmd = ACT_UP;
                    else if (key_byte == KEY_UPPER_B)
                        seq_cmd = ACT_DOWN;
                    else if (key_byte == KEY_UPPER_C)
                        seq_cmd = ACT_RIGHT;
                    else if (key_byte == KEY_UPPER_D)
                        seq_cmd = ACT_LEFT;
                    else if (key_byte == KEY_DIGIT_1)
                    begin
                        seq_cmd    = ACT_ENTER;
                        state_next = PS_TILDE;
                    end
                    else if (key_byte == KEY_DIGIT_2)
                    begin
                        seq_cmd    = ACT_SHIFT_LEFT;
                        state_next = PS_TILDE;
                    end
                    else if (key_byte == KEY_DIGIT_5)
                    begin
                        seq_cmd    = ACT_SHIFT_RIGHT;
                        state_next = PS_TILDE;
                    end
                    else
                        plain_en = 1'b1;
                end
                PS_TILDE:
                begin
                    state_next = PS_IDLE;
                    plain_en   = (key_byte != KEY_TILDE);
                end
                default:
                begin
                    state_next = PS_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        step.clear  = mode;
        step.erase  = plain_en && ((key_byte == KEY_BS) || (key_byte == KEY_DEL));
        step.append = plain_en && is_text;
        if (plain_en && ((key_byte == KEY_LF) || (key_byte == KEY_CR)))
            step.cmd = ACT_TYPED;
        else
            step.cmd = seq_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PS_IDLE;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

// File: sv/key_escape_sequence_decoder.sv
// Top level of the key escape sequence decoder with its typed-line buffer.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, key_byte and read_index.
//   Output channel (out_valid/out_ready) returns one transaction per input:
//   command, line_length and read_char (line character at read_index after
//   the step, 0 when read_index is not below line_length).
//   Throughput: one transaction per cycle while the receiver keeps up.
//   Pipeline: an accepted input is held in the pipeline stage and then in the
//   output register, which drives out_valid; the line memory has a registered
//   read port, which adds the pipeline stage ahead of the output register.
//   Reset: parser goes idle, the line is empty, both stages are empty.
//   The line memory is not cleared; unused positions are never reported.
//   Stall: when out_ready is low the output register holds its transaction
//   and the pipeline stage can still take one more input; after that
//   in_ready drops until the output drains.
`timescale 1ns / 1ps

module key_escape_sequence_decoder
    import kesd_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [7:0]                           key_byte,
    input  logic [4:0]                           read_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3:0]                           command,
    output logic [$clog2(LINE_CAPACITY + 1)-1:0] line_length,
    output logic [7:0]                           read_char
);

    localparam int COUNT_W = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W  = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int CMP_W   = ((COUNT_W > 5) ? COUNT_W : 5) + 1;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(LINE_CAPACITY);

    step_t              step;
    logic               in_accept;
    logic               o_free;
    logic               p_move;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CMP_W-1:0]   idx_ext;
    logic [COUNT_W-1:0] count_next;

    logic [COUNT_W-1:0] count_reg;
    logic               p_valid_reg;
    cmd_t               p_cmd_reg;
    logic [COUNT_W-1:0] p_len_reg;
    logic               p_hit_reg;
    logic               p_byp_reg;
    logic [7:0]         p_byte_reg;
    logic [7:0]         rdata_reg;
    logic               out_valid_reg;
    logic [3:0]         command_reg;
    logic [COUNT_W-1:0] line_length_reg;
    logic [7:0]         read_char_reg;

    logic [7:0] line_mem [LINE_CAPACITY];

    kesd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .mode     (mode),
        .key_byte (key_byte),
        .step     (step)
    );

    assign o_free    = !out_valid_reg || out_ready;
    assign p_move    = p_valid_reg && o_free;
    assign in_ready  = !p_valid_reg || o_free;
    assign in_accept = in_valid && in_ready;

    assign idx_ext = CMP_W'(read_index);
    assign rd_addr = idx_ext[ADDR_W-1:0];
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign mem_we  = in_accept && step.append && (count_reg < CAP);

    always_comb
    begin
        count_next = count_reg;
        if (step.clear)
            count_next = '0;
        else if (step.append && (count_reg < CAP))
            count_next = count_reg + COUNT_W'(1);
        else if (step.erase && (count_reg != '0))
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[wr_addr] <= key_byte;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            rdata_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                count_reg <= count_next;

            if (in_accept)
                p_valid_reg <= 1'b1;
            else if (p_move)
                p_valid_reg <= 1'b0;

            if (p_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage payload: capture the step result and the same-cycle write bypass.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_cmd_reg  <= step.cmd;
            p_len_reg  <= count_next;
            p_hit_reg  <= (idx_ext < CMP_W'(count_next));
            p_byp_reg  <= mem_we && (wr_addr == rd_addr);
            p_byte_reg <= key_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            command_reg     <= p_cmd_reg;
            line_length_reg <= p_len_reg;
            if (!p_hit_reg)
                read_char_reg <= 8'd0;
            else if (p_byp_reg)
                read_char_reg <= p_byte_reg;
            else
                read_char_reg <= rdata_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = command_reg;
    assign line_length = line_length_reg;
    assign read_char   = read_char_reg;

endmodule

// File: bench/key_escape_sequence_decoder_test.sv
// Self-checking testbench for the key escape sequence decoder and its typed-line buffer.
`timescale 1ns / 1ps

module key_escape_sequence_decoder_test
    import kesd_pkg::*;
;

    localparam int LINE_CAP      = 32;
    localparam int MAX_GAP       = 13;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 245;

    typedef enum logic [1:0] {
        PARSE_IDLE  = 2'd0,
        PARSE_ESC   = 2'd1,
        PARSE_CSI   = 2'd2,
        PARSE_TILDE = 2'd3
    } parse_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [5:0] length;
        logic [7:0] ch;
    } key_result_t;

    class key_line_tracker;
        parse_t      parse_st;
        logic [7:0]  chars [LINE_CAP];
        int unsigned fill;
        key_result_t awaited [$];
        int unsigned mismatches;

        function new();
            parse_st   = PARSE_IDLE;
            fill       = 0;
            mismatches = 0;
        endfunction

        function bit is_text(logic [7:0] b);
            return (b >= KEY_UPPER_A && b <= KEY_UPPER_Z) ||
                   (b >= KEY_LOWER_A && b <= KEY_LOWER_Z) ||
                   (b >= KEY_DIGIT_0 && b <= KEY_DIGIT_9) || b == KEY_SPACE;
        endfunction

        function cmd_t edit_line(logic [7:0] b);
            if (b == KEY_BS || b == KEY_DEL)
            begin
                if (fill > 0)
                    fill--;
            end
            else if (is_text(b))
            begin
                if (fill < LINE_CAP)
                begin
                    chars[fill] = b;
                    fill++;
                end
            end
            else if (b == KEY_LF || b == KEY_CR)
            begin
                return ACT_TYPED;
            end
            return ACT_NONE;
        endfunction

        function void take_key(logic m, logic [7:0] b, logic [4:0] idx);
            cmd_t        cmd;
            key_result_t r;
            cmd = ACT_NONE;
            if (m)
            begin
                fill = 0;
            end
            else if (b == KEY_BACKQUOTE)
            begin
                cmd = ACT_QUIT;
            end
            else
            begin
                case (parse_st)
                    PARSE_IDLE:
                    begin
                        if (b == KEY_ESC)
                            parse_st = PARSE_ESC;
                        else
                            cmd = edit_line(b);
                    end
                    PARSE_ESC:
                    begin
                        if (b == KEY_LBRACKET)
                        begin
                            parse_st = PARSE_CSI;
                        end
                        else
                        begin
                            parse_st = PARSE_IDLE;
                            cmd = edit_line(b);
                        end
                    end
                    PARSE_CSI:
                    begin
                        parse_st = PARSE_IDLE;
                        case (b)
                            KEY_UPPER_A: cmd = ACT_UP;
                            KEY_UPPER_B: cmd = ACT_DOWN;
                            KEY_UPPER_C: cmd = ACT_RIGHT;
                            KEY_UPPER_D: cmd = ACT_LEFT;
                            KEY_DIGIT_1:
                            begin
                                cmd = ACT_ENTER;
                                parse_st = PARSE_TILDE;
                            end
                            KEY_DIGIT_2:
                            begin
                                cmd = ACT_SHIFT_LEFT;
                                parse_st = PARSE_TILDE;
                            end
                            KEY_DIGIT_5:
                            begin
                                cmd = ACT_SHIFT_RIGHT;
                                parse_st = PARSE_TILDE;
                            end
                            default: cmd = edit_line(b);
                        endcase
                    end
                    default:
                    begin
                        parse_st = PARSE_IDLE;
                        if (b != KEY_TILDE)
                            cmd = edit_line(b);
                    end
                endcase
            end
            r.cmd    = cmd;
            r.length = fill[5:0];
            r.ch     = (idx < fill) ? chars[idx] : 8'd0;
            awaited.push_back(r);
        endfunction

        function void match_output(logic [3:0] c, logic [5:0] len, logic [7:0] ch);
            key_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected transaction: command %0d length %0d char %0d",
                             c, len, ch);
                return;
            end
            want = awaited.pop_front();
            if (c !== want.cmd || len !== want.length || ch !== want.ch)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: command %0d/%0d length %0d/%0d",
                              " char %0d/%0d (exp/act)"},
                             want.cmd, c, want.length, len, want.ch, ch);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [7:0] key_byte;
    logic [4:0] read_index;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] command;
    logic [5:0] line_length;
    logic [7:0] read_char;

    key_line_tracker tracker;
    bit              send_idles;
    bit              recv_idles;
    int unsigned     sent;
    int unsigned     quiet_cycles;

    key_escape_sequence_decoder #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key_byte   (key_byte),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .line_length(line_length),
        .read_char  (read_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_key(input logic m, input logic [7:0] b, input logic [4:0] idx);
        int unsigned gap;
        gap = send_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        key_byte   <= b;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.take_key(m, b, idx);
        sent++;
    endtask

    task automatic hold_until_drained();
        if (tracker.awaited.size() != 0)
        begin
            in_valid <= 1'b0;
            while (tracker.awaited.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [4:0] pick_index();
        if ($urandom_range(0, 1) == 1 && tracker.fill > 0)
            return 5'($urandom_range(0, tracker.fill - 1));
        return 5'($urandom_range(0, LINE_CAP - 1));
    endfunction

    function automatic logic [7:0] pick_text();
        int unsigned k;
        k = $urandom_range(0, 62);
        if (k < 26)
            return KEY_UPPER_A + 8'(k);
        if (k < 52)
            return KEY_LOWER_A + 8'(k - 26);
        if (k < 62)
            return KEY_DIGIT_0 + 8'(k - 52);
        return KEY_SPACE;
    endfunction

    task automatic send_escape();
        int unsigned tail;
        send_key(1'b0, KEY_ESC, pick_index());
        if ($urandom_range(0, 9) == 0)
        begin
            send_key(1'b0, 8'($urandom_range(0, 255)), pick_index());
            return;
        end
        send_key(1'b0, KEY_LBRACKET, pick_index());
        tail = $urandom_range(0, 9);
        case (tail)
            0: send_key(1'b0, KEY_UPPER_A, pick_index());
            1: send_key(1'b0, KEY_UPPER_B, pick_index());
            2: send_key(1'b0, KEY_UPPER_C, pick_index());
            3: send_key(1'b0, KEY_UPPER_D, pick_index());
            4, 5, 6:
            begin
                send_key(1'b0, (tail == 4) ? KEY_DIGIT_1 :
                               (tail == 5) ? KEY_DIGIT_2 : KEY_DIGIT_5, pick_index());
                if ($urandom_range(0, 3) != 0)
                    send_key(1'b0, KEY_TILDE, pick_index());
                else
                    send_key(1'b0, 8'($urandom_range(0, 255)), pick_index());
            end
            7: send_key(1'b0, KEY_BACKQUOTE, pick_index());
            8: send_key(1'b0, 8'($urandom_range(0, 255)), pick_index());
            default: send_key(1'b0, KEY_ESC, pick_index());
        endcase
    endtask

    task automatic send_random();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            send_key(1'b0, pick_text(), pick_index());
        else if (pick < 62)
            send_escape();
        else if (pick < 70)
            send_key(1'b0, $urandom_range(0, 1) ? KEY_BS : KEY_DEL, pick_index());
        else if (pick < 75)
            send_key(1'b0, $urandom_range(0, 1) ? KEY_CR : KEY_LF, pick_index());
        else if (pick < 78)
            send_key(1'b0, KEY_BACKQUOTE, pick_index());
        else if (pick < 81)
            send_key(1'b1, 8'($urandom_range(0, 255)), pick_index());
        else
            send_key(1'b0, 8'($urandom_range(0, 255)), pick_index());
    endtask

    initial
    begin
        int unsigned gap;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = recv_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            tracker.match_output(command, line_length, read_char);
        end
    end

    initial
    begin
        int unsigned target;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        mode         <= 1'b0;
        key_byte     <= 8'd0;
        read_index   <= 5'd0;
        tracker      = new();
        send_idles   = 1'b1;
        recv_idles   = 1'b1;
        sent         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_key(1'b1, 8'hFF, 5'd31);
        send_key(1'b0, KEY_BS, 5'd0);
        send_key(1'b0, KEY_DEL, 5'd31);
        send_key(1'b0, KEY_UPPER_A, 5'd0);
        send_key(1'b0, KEY_LOWER_Z, 5'd0);
        send_key(1'b0, KEY_DIGIT_0, 5'd1);
        send_key(1'b0, KEY_DIGIT_9, 5'd3);
        send_key(1'b0, KEY_SPACE, 5'd31);
        send_key(1'b0, KEY_ESC, 5'd4);
        send_key(1'b0, KEY_LBRACKET, 5'd4);
        send_key(1'b0, KEY_UPPER_A, 5'd2);
        send_key(1'b0, KEY_ESC, 5'd0);
        send_key(1'b0, KEY_LBRACKET, 5'd0);
        send_key(1'b0, KEY_DIGIT_1, 5'd0);
        send_key(1'b0, KEY_TILDE, 5'd5);
        send_key(1'b0, KEY_ESC, 5'd1);
        send_key(1'b0, KEY_LBRACKET, 5'd1);
        send_key(1'b0, KEY_DIGIT_5, 5'd1);
        send_key(1'b0, KEY_BACKQUOTE, 5'd1);
        send_key(1'b0, KEY_TILDE, 5'd5);
        send_key(1'b0, KEY_ESC, 5'd5);
        send_key(1'b0, KEY_LOWER_A + 8'd23, 5'd5);
        send_key(1'b0, KEY_ESC, 5'd2);
        send_key(1'b0, KEY_LBRACKET, 5'd2);
        send_key(1'b0, KEY_ESC, 5'd2);
        send_key(1'b0, KEY_CR, 5'd6);
        send_key(1'b0, 8'hFF, 5'd6);
        hold_until_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            send_idles = (phase == 0 || phase == 2 || phase == 4);
            recv_idles = (phase == 0 || phase == 3 || phase == 4);
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                send_random();
                if ($urandom_range(0, 199) == 0)
                    hold_until_drained();
            end
            if (phase == 1)
                hold_until_drained();
        end

        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
sv/kesd_pkg.sv
sv/kesd_parser.sv
sv/key_escape_sequence_decoder.sv
bench/key_escape_sequence_decoder_test.sv
